@@ rtl/core/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg
// shared constants and codes of the software timer service
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int POOL_SIZE = 16;
  localparam int SLOT_W    = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);
  localparam int MAX_FIRE  = 16;
  localparam int INFO_W    = 32 + 32 + 8;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_RESET  = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_FIRED    = 3'd1;
  localparam logic [2:0] ST_NONE_DUE = 3'd2;
  localparam logic [2:0] ST_BAD_DEST = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_ZERO_PER = 3'd5;
  localparam logic [2:0] ST_NOT_RUN  = 3'd6;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd7;

endpackage

@@ rtl/core/sts_ram.sv @@
// ----------------------------------------------------------------------------
// sts_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/software_timer_service_top.sv @@
// ----------------------------------------------------------------------------
// software_timer_service_top
// pool of sixteen software timers driven by commands and a system tick
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request
// ends with a scan of the expiry ram, one slot a cycle; a reset passes
// through an apply state before its scan. A tick spends one scan per
// fired timer plus one. Results appear on done_o for exactly one cycle each,
// last_o marks the final one; the receiver cannot stall them.
module software_timer_service_top
  import sts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [2:0]         cmd_i,
  input  logic [31:0]        now_tick_i,
  input  logic [3:0]         slot_i,
  input  logic [31:0]        delay_i,
  input  logic [31:0]        period_ticks_i,
  input  logic               periodic_i,
  input  logic signed [31:0] signal_code_i,
  input  logic [7:0]         dest_task_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [3:0]         out_slot_o,
  output logic signed [31:0] out_signal_o,
  output logic [7:0]         out_dest_o,
  output logic [31:0]        ticks_to_next_o,
  output logic               last_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_RST_APPLY, S_SCAN, S_DECIDE, S_FIRE
  } state_e;

  state_e            state_q;
  logic [7:0]        task_count_q;
  logic [31:0]       idle_limit_q;
  logic [POOL_SIZE-1:0] alloc_q, armed_q, side_q;
  logic [SLOT_W-1:0] rank_q [POOL_SIZE];
  logic [SLOT_W-1:0] free_q [POOL_SIZE];
  logic [CNT_W-1:0]  used_q;
  logic              cur_side_q;
  logic [31:0]       prev_tick_q;
  logic [31:0]       now_q;
  logic [SLOT_W-1:0] slot_q;
  logic              tick_q;
  logic [2:0]        res_status_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [CNT_W-1:0]  scan_cnt_q;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              found_q;
  logic [SLOT_W-1:0] best_idx_q;
  logic [31:0]       best_exp_q;
  logic [SLOT_W-1:0] best_rank_q;
  logic [CNT_W-1:0]  fired_q;
  logic              pend_q;
  logic [SLOT_W-1:0] pend_slot_q;
  logic [31:0]       pend_sig_q;
  logic [7:0]        pend_dest_q;

  logic              exp_we, info_we;
  logic [SLOT_W-1:0] info_waddr, info_raddr;
  logic [INFO_W-1:0] info_wdata, info_rdata;
  logic [31:0]       exp_rdata;

  logic              upd_en, upd_relink;
  logic [SLOT_W-1:0] upd_tgt;
  logic [31:0]       upd_exp, upd_now;
  logic [CNT_W-1:0]  armed_cnt;
  logic [SLOT_W-1:0] other_cnt;

  logic              accept, slot_ok, create_ok, due;
  logic [31:0]       rel_rd, ticks_val;

  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;
  assign slot_ok    = alloc_q[slot_i];
  assign create_ok  = (({1'b0, dest_task_i} + 9'd1) < {1'b0, task_count_q})
                      && (used_q < CNT_W'(POOL_SIZE))
                      && !(periodic_i && (period_ticks_i == 32'd0));
  assign rel_rd     = info_rdata[INFO_W-1 -: 32];
  assign due        = tick_q && found_q && (best_exp_q <= now_q)
                      && (fired_q < CNT_W'(MAX_FIRE));
  assign ticks_val  = (found_q ? best_exp_q : idle_limit_q) - now_q;
  assign info_raddr = (state_q == S_IDLE) ? slot_i : best_idx_q;
  assign info_we    = accept && (cmd_i == CMD_CREATE) && create_ok;
  assign info_waddr = free_q[used_q[SLOT_W-1:0]];
  assign info_wdata = {(periodic_i ? period_ticks_i : 32'd0), signal_code_i, dest_task_i};
  assign exp_we     = upd_en && upd_relink;

  always_comb begin
    armed_cnt = '0;
    for (int t = 0; t < POOL_SIZE; t++) begin
      armed_cnt = armed_cnt + CNT_W'(armed_q[t]);
    end
  end

  assign other_cnt = SLOT_W'(armed_cnt - CNT_W'(armed_q[upd_tgt]));

  always_comb begin
    upd_en     = 1'b0;
    upd_relink = 1'b0;
    upd_tgt    = slot_i;
    upd_exp    = now_tick_i + delay_i;
    upd_now    = now_tick_i;
    case (state_q)
      S_IDLE: begin
        if (accept && slot_ok && (cmd_i == CMD_START)) begin
          upd_en     = 1'b1;
          upd_relink = 1'b1;
        end else if (accept && slot_ok && (cmd_i == CMD_REMOVE)) begin
          upd_en = 1'b1;
        end
      end
      S_RST_APPLY: begin
        upd_en     = 1'b1;
        upd_tgt    = slot_q;
        upd_relink = (rel_rd != 32'd0);
        upd_exp    = rel_rd + now_q;
        upd_now    = now_q;
      end
      S_FIRE: begin
        upd_en     = 1'b1;
        upd_tgt    = best_idx_q;
        upd_relink = (rel_rd != 32'd0);
        upd_exp    = rel_rd + now_q;
        upd_now    = now_q;
      end
      default: begin
      end
    endcase
  end

  sts_ram #(.Width(32), .Depth(POOL_SIZE)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .waddr_i (upd_tgt),
    .wdata_i (upd_exp),
    .raddr_i (scan_cnt_q[SLOT_W-1:0]),
    .rdata_o (exp_rdata)
  );

  sts_ram #(.Width(INFO_W), .Depth(POOL_SIZE)) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (info_waddr),
    .wdata_i (info_wdata),
    .raddr_i (info_raddr),
    .rdata_o (info_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      task_count_q <= 8'd16;
      idle_limit_q <= 32'hFFFF_FFFF;
      alloc_q      <= '0;
      armed_q      <= '0;
      side_q       <= '0;
      for (int i = 0; i < POOL_SIZE; i++) begin
        rank_q[i] <= '0;
        free_q[i] <= SLOT_W'(i);
      end
      used_q       <= '0;
      cur_side_q   <= 1'b0;
      prev_tick_q  <= '0;
      now_q        <= '0;
      slot_q       <= '0;
      tick_q       <= 1'b0;
      res_status_q <= ST_DONE;
      res_slot_q   <= '0;
      scan_cnt_q   <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_exp_q   <= '0;
      best_rank_q  <= '0;
      fired_q      <= '0;
      pend_q       <= 1'b0;
      pend_slot_q  <= '0;
      pend_sig_q   <= '0;
      pend_dest_q  <= '0;
      done_o       <= 1'b0;
      status_o     <= ST_DONE;
      out_slot_o   <= '0;
      out_signal_o <= '0;
      out_dest_o   <= '0;
      ticks_to_next_o <= '0;
      last_o       <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == 1'b0) begin
          task_count_q <= cfg_data_i[7:0];
        end else begin
          idle_limit_q <= cfg_data_i;
        end
      end

      // unlink, then relink or release
      if (upd_en) begin
        for (int t = 0; t < POOL_SIZE; t++) begin
          if (armed_q[t] && armed_q[upd_tgt] && (rank_q[t] > rank_q[upd_tgt])) begin
            rank_q[t] <= rank_q[t] - SLOT_W'(1);
          end
        end
        if (upd_relink) begin
          armed_q[upd_tgt] <= 1'b1;
          rank_q[upd_tgt]  <= other_cnt;
          side_q[upd_tgt]  <= (upd_exp < upd_now) ? ~cur_side_q : cur_side_q;
        end else begin
          armed_q[upd_tgt] <= 1'b0;
          alloc_q[upd_tgt] <= 1'b0;
          if (used_q != '0) begin
            used_q <= used_q - CNT_W'(1);
            free_q[SLOT_W'(used_q - CNT_W'(1))] <= upd_tgt;
          end
        end
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            now_q        <= now_tick_i;
            slot_q       <= slot_i;
            tick_q       <= (cmd_i == CMD_TICK);
            res_status_q <= ST_DONE;
            res_slot_q   <= '0;
            fired_q      <= '0;
            pend_q       <= 1'b0;
            scan_cnt_q   <= '0;
            rd_vld_q     <= 1'b0;
            found_q      <= 1'b0;
            state_q      <= S_SCAN;
            case (cmd_i)
              CMD_CREATE: begin
                if (({1'b0, dest_task_i} + 9'd1) >= {1'b0, task_count_q}) begin
                  res_status_q <= ST_BAD_DEST;
                end else if (used_q >= CNT_W'(POOL_SIZE)) begin
                  res_status_q <= ST_FULL;
                end else if (periodic_i && (period_ticks_i == 32'd0)) begin
                  res_status_q <= ST_ZERO_PER;
                end else begin
                  res_slot_q        <= info_waddr;
                  alloc_q[info_waddr] <= 1'b1;
                  armed_q[info_waddr] <= 1'b0;
                  used_q            <= used_q + CNT_W'(1);
                end
              end
              CMD_START, CMD_REMOVE: begin
                if (!slot_ok) begin
                  res_status_q <= ST_NOT_ALLOC;
                end
              end
              CMD_RESET: begin
                if (!slot_ok) begin
                  res_status_q <= ST_NOT_ALLOC;
                end else if (!armed_q[slot_i]) begin
                  res_status_q <= ST_NOT_RUN;
                end else begin
                  state_q <= S_RST_APPLY;
                end
              end
              CMD_TICK: begin
                if (now_tick_i < prev_tick_q) begin
                  cur_side_q <= ~cur_side_q;
                end
                prev_tick_q <= now_tick_i;
              end
              default: begin
              end
            endcase
          end
        end
        S_RST_APPLY: begin
          scan_cnt_q <= '0;
          rd_vld_q   <= 1'b0;
          found_q    <= 1'b0;
          state_q    <= S_SCAN;
        end
        S_SCAN: begin
          rd_vld_q <= (scan_cnt_q < CNT_W'(POOL_SIZE));
          rd_idx_q <= scan_cnt_q[SLOT_W-1:0];
          if (scan_cnt_q < CNT_W'(POOL_SIZE)) begin
            scan_cnt_q <= scan_cnt_q + CNT_W'(1);
          end
          if (rd_vld_q && armed_q[rd_idx_q] && (side_q[rd_idx_q] == cur_side_q)) begin
            if (!found_q || (exp_rdata < best_exp_q) ||
                ((exp_rdata == best_exp_q) && (rank_q[rd_idx_q] < best_rank_q))) begin
              found_q     <= 1'b1;
              best_idx_q  <= rd_idx_q;
              best_exp_q  <= exp_rdata;
              best_rank_q <= rank_q[rd_idx_q];
            end
          end
          if ((scan_cnt_q == CNT_W'(POOL_SIZE)) && !rd_vld_q) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (due) begin
            if (pend_q) begin
              done_o       <= 1'b1;
              status_o     <= ST_FIRED;
              out_slot_o   <= pend_slot_q;
              out_signal_o <= pend_sig_q;
              out_dest_o   <= pend_dest_q;
              ticks_to_next_o <= '0;
              last_o       <= 1'b0;
            end
            state_q <= S_FIRE;
          end else begin
            done_o          <= 1'b1;
            ticks_to_next_o <= ticks_val;
            last_o          <= 1'b1;
            if (tick_q && pend_q) begin
              status_o     <= ST_FIRED;
              out_slot_o   <= pend_slot_q;
              out_signal_o <= pend_sig_q;
              out_dest_o   <= pend_dest_q;
            end else begin
              status_o     <= tick_q ? ST_NONE_DUE : res_status_q;
              out_slot_o   <= tick_q ? '0 : res_slot_q;
              out_signal_o <= '0;
              out_dest_o   <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        S_FIRE: begin
          pend_q      <= 1'b1;
          pend_slot_q <= best_idx_q;
          pend_sig_q  <= info_rdata[39:8];
          pend_dest_q <= info_rdata[7:0];
          fired_q     <= fired_q + CNT_W'(1);
          scan_cnt_q  <= '0;
          rd_vld_q    <= 1'b0;
          found_q     <= 1'b0;
          state_q     <= S_SCAN;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  logic [CNT_W-1:0] alloc_cnt;
  always_comb begin
    alloc_cnt = '0;
    for (int t = 0; t < POOL_SIZE; t++) begin
      alloc_cnt = alloc_cnt + CNT_W'(alloc_q[t]);
    end
  end

  a_used_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_cnt == used_q) else $error("used count differs from allocated slots");

  a_armed_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q & ~alloc_q) == '0) else $error("armed slot not allocated");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (done_o && last_o)) else $error("request ended without last");
`endif

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the software timer service: an in-bench predictor
// follows every accepted request and each strobed result is compared field by
// field; directed cases first, then random timer traffic under several
// register settings, with random gaps on the request side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sts_pkg::*;

  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam logic REG_TASK_COUNT = 1'b0;
  localparam logic REG_IDLE_WAIT  = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] now;
    logic [3:0]  slot;
    logic [31:0] delay;
    logic [31:0] period;
    logic        periodic;
    logic [31:0] sig;
    logic [7:0]  dest;
  } timer_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] sig;
    logic [7:0]  dest;
    logic [31:0] wait_ticks;
    logic        last;
  } timer_evt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic [2:0] cmd_i = '0;
  logic [31:0] now_tick_i = '0;
  logic [3:0] slot_i = '0;
  logic [31:0] delay_i = '0;
  logic [31:0] period_ticks_i = '0;
  logic periodic_i = 1'b0;
  logic signed [31:0] signal_code_i = '0;
  logic [7:0] dest_task_i = '0;
  logic done_o;
  logic [2:0] status_o;
  logic [3:0] out_slot_o;
  logic signed [31:0] out_signal_o;
  logic [7:0] out_dest_o;
  logic [31:0] ticks_to_next_o;
  logic last_o;

  software_timer_service_top dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  m_task_count;
  logic [31:0] m_idle_wait;
  logic        m_alloc [POOL_SIZE];
  logic        m_armed [POOL_SIZE];
  logic [31:0] m_expiry [POOL_SIZE];
  logic [31:0] m_reload [POOL_SIZE];
  logic [31:0] m_sig [POOL_SIZE];
  logic [7:0]  m_dest [POOL_SIZE];
  logic        m_side [POOL_SIZE];
  int          m_rank [POOL_SIZE];
  logic [3:0]  m_free [POOL_SIZE];
  int          m_used;
  logic        m_cur_side;
  logic [31:0] m_prev_tick;

  timer_evt_t expected_evts [$];
  int mismatches = 0;
  int n_reqs = 0;
  int n_evts = 0;
  int n_fired = 0;
  logic [31:0] sys_now = '0;
  bit no_gaps = 0;

  task automatic model_reset();
    m_task_count = 8'd16;
    m_idle_wait = '1;
    m_used = 0;
    m_cur_side = 1'b0;
    m_prev_tick = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      m_alloc[i] = 0; m_armed[i] = 0; m_expiry[i] = 0; m_reload[i] = 0;
      m_sig[i] = 0; m_dest[i] = 0; m_side[i] = 0; m_rank[i] = 0;
      m_free[i] = 4'(i);
    end
  endtask

  task automatic take_off(int s);
    if (m_armed[s]) begin
      for (int t = 0; t < POOL_SIZE; t++)
        if (m_armed[t] && m_rank[t] > m_rank[s]) m_rank[t]--;
      m_armed[s] = 0;
    end
  endtask

  task automatic put_on(int s, logic [31:0] now);
    int n;
    n = 0;
    for (int t = 0; t < POOL_SIZE; t++) if (m_armed[t]) n++;
    m_side[s] = (m_expiry[s] < now) ? ~m_cur_side : m_cur_side;
    m_rank[s] = n;
    m_armed[s] = 1;
  endtask

  task automatic free_slot(int s);
    take_off(s);
    m_alloc[s] = 0;
    if (m_used > 0) begin
      m_used--;
      m_free[m_used] = 4'(s);
    end
  endtask

  function automatic int soonest();
    int best;
    best = -1;
    for (int t = 0; t < POOL_SIZE; t++) begin
      if (!m_armed[t] || m_side[t] != m_cur_side) continue;
      if (best < 0 || m_expiry[t] < m_expiry[best] ||
          (m_expiry[t] == m_expiry[best] && m_rank[t] < m_rank[best]))
        best = t;
    end
    return best;
  endfunction

  task automatic predict_timer_events(timer_req_t r);
    timer_evt_t ev [$];
    timer_evt_t e;
    int s, m;
    logic [31:0] nxt;
    bit ok;
    ok = m_alloc[r.slot];
    e = '0;
    case (r.cmd)
      CMD_CREATE: begin
        if (32'(r.dest) + 32'd1 >= 32'(m_task_count)) e.status = ST_BAD_DEST;
        else if (m_used >= POOL_SIZE) e.status = ST_FULL;
        else if (r.periodic && r.period == 0) e.status = ST_ZERO_PER;
        else begin
          s = m_free[m_used];
          m_used++;
          m_alloc[s] = 1; m_armed[s] = 0;
          m_reload[s] = r.periodic ? r.period : 32'd0;
          m_sig[s] = r.sig; m_dest[s] = r.dest;
          e.status = ST_DONE; e.slot = 4'(s);
        end
        ev.push_back(e);
      end
      CMD_START: begin
        if (!ok) e.status = ST_NOT_ALLOC;
        else begin
          take_off(r.slot);
          m_expiry[r.slot] = r.now + r.delay;
          put_on(r.slot, r.now);
          e.status = ST_DONE;
        end
        ev.push_back(e);
      end
      CMD_RESET: begin
        if (!ok) e.status = ST_NOT_ALLOC;
        else if (!m_armed[r.slot]) e.status = ST_NOT_RUN;
        else begin
          take_off(r.slot);
          if (m_reload[r.slot] != 0) begin
            m_expiry[r.slot] = m_reload[r.slot] + r.now;
            put_on(r.slot, r.now);
          end else free_slot(r.slot);
          e.status = ST_DONE;
        end
        ev.push_back(e);
      end
      CMD_REMOVE: begin
        if (!ok) e.status = ST_NOT_ALLOC;
        else begin
          free_slot(r.slot);
          e.status = ST_DONE;
        end
        ev.push_back(e);
      end
      CMD_TICK: begin
        if (r.now < m_prev_tick) m_cur_side = ~m_cur_side;
        while (ev.size() < MAX_FIRE) begin
          m = soonest();
          if (m < 0) break;
          if (m_expiry[m] > r.now) break;
          take_off(m);
          e = '0;
          e.status = ST_FIRED; e.slot = 4'(m); e.sig = m_sig[m]; e.dest = m_dest[m];
          ev.push_back(e);
          n_fired++;
          if (m_reload[m] != 0) begin
            m_expiry[m] = m_reload[m] + r.now;
            put_on(m, r.now);
          end else free_slot(m);
        end
        m_prev_tick = r.now;
        if (ev.size() == 0) begin
          e = '0;
          e.status = ST_NONE_DUE;
          ev.push_back(e);
        end
      end
      default: ev.push_back(e);
    endcase
    m = soonest();
    nxt = (m < 0) ? m_idle_wait : m_expiry[m];
    ev[ev.size()-1].wait_ticks = nxt - r.now;
    ev[ev.size()-1].last = 1'b1;
    foreach (ev[i]) expected_evts.push_back(ev[i]);
  endtask

  // result checker
  always @(negedge clk_i) begin
    timer_evt_t got, want;
    if (rst_ni && done_o) begin
      got = '{status_o, out_slot_o, out_signal_o, out_dest_o, ticks_to_next_o, last_o};
      n_evts++;
      if (expected_evts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_evts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // caller must be just past a rising edge
  task automatic send_request(timer_req_t r);
    bit ok;
    int g;
    start <= 1'b1;
    cmd_i <= r.cmd; now_tick_i <= r.now; slot_i <= r.slot; delay_i <= r.delay;
    period_ticks_i <= r.period; periodic_i <= r.periodic;
    signal_code_i <= r.sig; dest_task_i <= r.dest;
    do begin
      @(negedge clk_i);
      ok = !busy;
      @(posedge clk_i);
    end while (!ok);
    predict_timer_events(r);
    n_reqs++;
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_evts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_TASK_COUNT) m_task_count = val[7:0];
    else m_idle_wait = val;
  endtask

  function automatic timer_req_t mk(logic [2:0] c, logic [31:0] now, logic [3:0] sl,
                                    logic [31:0] dl, logic [31:0] pr, logic pe,
                                    logic [31:0] sg, logic [7:0] ds);
    timer_req_t r;
    r = '{c, now, sl, dl, pr, pe, sg, ds};
    return r;
  endfunction

  task automatic test_directed();
    send_request(mk(CMD_CREATE, 0, 0, 0, 5, 1, 32'h7fffffff, 8'd255));
    send_request(mk(CMD_CREATE, 0, 0, 0, 5, 1, 32'h1, 8'd15));
    send_request(mk(CMD_CREATE, 0, 0, 0, 0, 1, 32'h2, 8'd3));
    send_request(mk(CMD_CREATE, 0, 0, 0, 32'hffffffff, 1, 32'h80000000, 8'd14));
    send_request(mk(CMD_CREATE, 0, 0, 0, 77, 0, 32'hffffffff, 8'd0));
    send_request(mk(CMD_START, 0, 4'd9, 10, 0, 0, 0, 0));
    send_request(mk(CMD_RESET, 0, 4'd1, 0, 0, 0, 0, 0));
    send_request(mk(CMD_START, 10, 4'd0, 5, 0, 0, 0, 0));
    send_request(mk(CMD_START, 10, 4'd1, 5, 0, 0, 0, 0));
    send_request(mk(CMD_START, 11, 4'd0, 4, 0, 0, 0, 0));
    send_request(mk(CMD_TICK, 12, 0, 0, 0, 0, 0, 0));
    send_request(mk(CMD_TICK, 15, 0, 0, 0, 0, 0, 0));
    send_request(mk(CMD_RESET, 16, 4'd0, 0, 0, 0, 0, 0));
    send_request(mk(CMD_START, 16, 4'd1, 32'hffffffff, 0, 0, 0, 0));
    send_request(mk(CMD_RESET, 17, 4'd1, 0, 0, 0, 0, 0));
    send_request(mk(CMD_REMOVE, 17, 4'd0, 0, 0, 0, 0, 0));
    send_request(mk(CMD_REMOVE, 17, 4'd0, 0, 0, 0, 0, 0));
    send_request(mk(CMD_SPARE_5, 18, 4'd3, 0, 0, 0, 0, 0));
    send_request(mk(CMD_SPARE_7, 18, 4'd3, 0, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      send_request(mk(CMD_CREATE, 20, 0, 0, 3, 1, $urandom, 8'(i % 14)));
    for (int i = 0; i < 16; i++)
      send_request(mk(CMD_START, 20, 4'(i), 4'(i % 3), 0, 0, 0, 0));
    send_request(mk(CMD_TICK, 25, 0, 0, 0, 0, 0, 0));
    // wrap: tick count runs past the top and expiries land on the other side
    send_request(mk(CMD_START, 32'hfffffff0, 4'd2, 32'h20, 0, 0, 0, 0));
    send_request(mk(CMD_TICK, 32'hfffffff8, 0, 0, 0, 0, 0, 0));
    send_request(mk(CMD_TICK, 32'h00000030, 0, 0, 0, 0, 0, 0));
    sys_now = 32'h40;
    settle();
  endtask

  task automatic test_random(int count);
    timer_req_t r;
    int k;
    for (int i = 0; i < count; i++) begin
      r = '0;
      r.sig = $urandom;
      k = $urandom_range(0, 99);
      if (k < 20) r.cmd = CMD_CREATE;
      else if (k < 45) r.cmd = CMD_START;
      else if (k < 55) r.cmd = CMD_RESET;
      else if (k < 65) r.cmd = CMD_REMOVE;
      else if (k < 97) r.cmd = CMD_TICK;
      else r.cmd = 3'($urandom_range(5, 7));
      k = $urandom_range(0, 99);
      if (r.cmd == CMD_TICK) begin
        if (k < 4) sys_now = $urandom;
        else if (k < 8) sys_now = sys_now + 32'hffffffff - 32'($urandom_range(0, 50));
        else sys_now = sys_now + 32'($urandom_range(0, 12));
      end
      r.now = sys_now;
      r.slot = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
      r.delay = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40));
      r.periodic = $urandom_range(0, 1);
      k = $urandom_range(0, 19);
      r.period = (k == 0) ? 32'd0 : (k == 1) ? $urandom : 32'($urandom_range(1, 30));
      r.dest = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
               8'($urandom_range(0, (m_task_count > 2) ? m_task_count - 2 : 0));
      send_request(r);
    end
    settle();
  endtask

  task automatic test_settings();
    write_reg(REG_TASK_COUNT, 32'd1);
    write_reg(REG_IDLE_WAIT, 32'd0);
    test_random(25);
    write_reg(REG_TASK_COUNT, 32'd0);
    write_reg(REG_IDLE_WAIT, $urandom);
    test_random(25);
    write_reg(REG_TASK_COUNT, 32'd255);
    write_reg(REG_IDLE_WAIT, 32'hffffffff);
    test_random(110);
    no_gaps = 1;
    test_random(50);
    no_gaps = 0;
    write_reg(REG_TASK_COUNT, 32'd16);
    test_random(54);
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random(40);
    test_settings();
    $display("%0d requests, %0d results (%0d timers fired) over five register settings",
             n_reqs, n_evts, n_fired);
    if (mismatches == 0 && expected_evts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_evts.size());
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("FAIL");
    $finish;
  end

endmodule
